### hw/rtl/srrw_pkg.sv
// shared constants and types of the selective-repeat receiver window
package srrw_pkg;

  localparam int SEQ_W   = 32;
  localparam int FLAG_W  = 2;
  localparam int KIND_W  = 2;
  localparam int WLEN_W  = 6;
  localparam int CFG_W   = 32;
  localparam int CFG_IDX_W = 1;

  // remainder unit: bits of the sequence number folded in per cycle
  localparam int MOD_STEP   = 4;
  localparam int MOD_CYCLES = SEQ_W / MOD_STEP;

  typedef logic [SEQ_W-1:0]     seq_t;
  typedef logic [KIND_W-1:0]    kind_t;
  typedef logic [FLAG_W-1:0]    flag_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam kind_t KIND_ACK     = 2'd0;
  localparam kind_t KIND_DELIVER = 2'd1;
  localparam kind_t KIND_FIN     = 2'd2;

  localparam flag_t FLAG_NONE = 2'd0;
  localparam flag_t FLAG_FIN  = 2'd1;

  localparam cfg_idx_t REG_WINDOW_LEN = 1'b0;
  localparam cfg_idx_t REG_START_SEQ  = 1'b1;

endpackage

### hw/rtl/srrw_ram.sv
// generic single-write, single-read ram with registered read
module srrw_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 32
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/srrw_mod.sv
// multi-cycle remainder of a sequence number by the window length
module srrw_mod #(
  parameter int DIVW = 6
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 go,
  input  srrw_pkg::seq_t       dividend,
  input  logic [DIVW-1:0]      divisor,
  output logic                 done,
  output logic [DIVW-1:0]      rem
);
  import srrw_pkg::*;

  localparam int CW = (MOD_CYCLES > 1) ? $clog2(MOD_CYCLES) : 1;
  localparam logic [CW-1:0] CNT_LAST = CW'(MOD_CYCLES - 1);

  logic            run_r, run_nxt;
  logic            done_r, done_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  seq_t            sh_r, sh_nxt;
  logic [DIVW-1:0] r_r, r_nxt;
  logic [DIVW-1:0] dv_r, dv_nxt;
  logic [DIVW-1:0] r_step;

  // restoring remainder, MOD_STEP bits a cycle
  always_comb begin
    logic [DIVW:0] t;
    r_step = r_r;
    for (int k = 0; k < MOD_STEP; k++) begin
      t = {r_step, sh_r[SEQ_W-1-k]};
      if (t >= {1'b0, dv_r}) begin
        t = t - {1'b0, dv_r};
      end
      r_step = t[DIVW-1:0];
    end
  end

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    sh_nxt   = sh_r;
    r_nxt    = r_r;
    dv_nxt   = dv_r;
    if (go) begin
      run_nxt = 1'b1;
      cnt_nxt = '0;
      sh_nxt  = dividend;
      r_nxt   = '0;
      dv_nxt  = divisor;
    end else if (run_r) begin
      sh_nxt  = sh_r << MOD_STEP;
      r_nxt   = r_step;
      cnt_nxt = cnt_r + CW'(1);
      if (cnt_r == CNT_LAST) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    sh_r  <= sh_nxt;
    r_r   <= r_nxt;
    dv_r  <= dv_nxt;
  end

  assign done = done_r;
  assign rem  = r_r;

endmodule

### hw/rtl/selective_repeat_receiver_window.sv
// Selective-repeat receiver window over packet headers. A header is taken when start is high
// and busy is low; each result word appears on the out_ ports for exactly one cycle with
// out_valid high and cannot be held off. FIN, flagged, beyond-window, old and post-finish
// headers leave busy low: their result, if any, shows the cycle after acceptance. A header
// inside the window needs its slot, seq_num mod window_len, from a remainder unit that
// folds in 4 bits a cycle, then one read of the slot ram; busy stays high through these and
// through any in-order delivery that follows, since the flush reads one slot a cycle
// through the single read port of the slot ram. Acknowledge flags clear at once on reset
// and on a start_seq write; there is no clearing pass.
module selective_repeat_receiver_window #(
  parameter int WINDOW_MAX = 32,
  parameter int LEN_BITS   = 11
) (
  input  logic                                            clk,
  input  logic                                            rst_n,
  input  logic                                            start,
  output logic                                            busy,
  input  srrw_pkg::seq_t                                  in_seq_num,
  input  srrw_pkg::flag_t                                 in_flag_kind,
  input  logic [LEN_BITS-1:0]                             in_payload_len,
  input  logic                                            in_check_ok,
  output logic                                            out_valid,
  output srrw_pkg::kind_t                                 out_kind,
  output srrw_pkg::seq_t                                  out_seq_out,
  output logic [((WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1)-1:0] out_slot,
  output logic [LEN_BITS-1:0]                             out_len_out,
  output logic                                            out_last,
  input  logic                                            cfg_we,
  input  srrw_pkg::cfg_idx_t                              cfg_index,
  input  logic [srrw_pkg::CFG_W-1:0]                      cfg_data
);
  import srrw_pkg::*;

  localparam int SLOT_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int WW     = $clog2(WINDOW_MAX + 1);
  localparam int RAM_W  = LEN_BITS + 1;
  localparam logic [WLEN_W-1:0] WMAX_L  = WLEN_W'(WINDOW_MAX);
  localparam logic [WLEN_W-1:0] WLEN_RST = WLEN_W'(8);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_MOD   = 2'd1;
  localparam logic [1:0] S_LOOK  = 2'd2;
  localparam logic [1:0] S_FLUSH = 2'd3;

  logic [1:0]            state_r, state_nxt;
  logic [WLEN_W-1:0]     wlen_r, wlen_nxt;
  seq_t                  left_r, left_nxt;
  logic                  fin_r, fin_nxt;
  logic [WINDOW_MAX-1:0] vld_r, vld_nxt;

  seq_t                  seq_r, seq_nxt;
  logic [LEN_BITS-1:0]   len_r, len_nxt;
  logic                  ok_r, ok_nxt;
  logic                  zero_r, zero_nxt;
  logic [SLOT_W-1:0]     idx_r, idx_nxt;
  logic [SLOT_W-1:0]     j_r, j_nxt;
  logic [WW-1:0]         cnt_r, cnt_nxt;
  seq_t                  pseq_r, pseq_nxt;
  logic [SLOT_W-1:0]     pslot_r, pslot_nxt;
  logic [LEN_BITS-1:0]   plen_r, plen_nxt;

  logic                  ov_r, ov_nxt;
  kind_t                 ok_kind_r, ok_kind_nxt;
  seq_t                  oseq_r, oseq_nxt;
  logic [SLOT_W-1:0]     oslot_r, oslot_nxt;
  logic [LEN_BITS-1:0]   olen_r, olen_nxt;
  logic                  olast_r, olast_nxt;

  logic [WW-1:0]         win;
  logic                  acc;
  seq_t                  seq_dist;
  logic                  is_old, beyond;
  logic                  mod_go, mod_done;
  logic [WW-1:0]         mod_rem;
  logic                  ram_we;
  logic [SLOT_W-1:0]     ram_waddr, ram_raddr;
  logic [RAM_W-1:0]      ram_wdata, ram_rdata;
  logic [SLOT_W-1:0]     j_after_idx, j_after_j;
  logic                  cand;

  // effective window length, clamped to 1..WINDOW_MAX
  always_comb begin
    if (wlen_r == '0) begin
      win = WW'(1);
    end else if (wlen_r > WMAX_L) begin
      win = WW'(WINDOW_MAX);
    end else begin
      win = WW'(wlen_r);
    end
  end

  assign busy     = (state_r != S_IDLE);
  assign acc      = start && !busy;
  assign seq_dist = in_seq_num - left_r;
  assign is_old   = seq_dist[SEQ_W-1];
  assign beyond   = !seq_dist[SEQ_W-1] && (seq_dist >= SEQ_W'(win));

  assign j_after_idx = ((WW'(idx_r) + WW'(1)) == win) ? '0 : idx_r + SLOT_W'(1);
  assign j_after_j   = ((WW'(j_r) + WW'(1)) == win) ? '0 : j_r + SLOT_W'(1);
  assign cand = (cnt_r < win) && vld_r[j_r] && ram_rdata[LEN_BITS];

  // the remainder unit loads the header at the accepting edge
  srrw_mod #(
    .DIVW(WW)
  ) u_mod (
    .clk     (clk),
    .rst_n   (rst_n),
    .go      (mod_go),
    .dividend(in_seq_num),
    .divisor (win),
    .done    (mod_done),
    .rem     (mod_rem)
  );

  srrw_ram #(
    .WIDTH(RAM_W),
    .DEPTH(WINDOW_MAX)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_comb begin
    state_nxt   = state_r;
    wlen_nxt    = wlen_r;
    left_nxt    = left_r;
    fin_nxt     = fin_r;
    vld_nxt     = vld_r;
    seq_nxt     = seq_r;
    len_nxt     = len_r;
    ok_nxt      = ok_r;
    zero_nxt    = zero_r;
    idx_nxt     = idx_r;
    j_nxt       = j_r;
    cnt_nxt     = cnt_r;
    pseq_nxt    = pseq_r;
    pslot_nxt   = pslot_r;
    plen_nxt    = plen_r;
    ov_nxt      = 1'b0;
    ok_kind_nxt = ok_kind_r;
    oseq_nxt    = oseq_r;
    oslot_nxt   = oslot_r;
    olen_nxt    = olen_r;
    olast_nxt   = olast_r;
    mod_go      = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = idx_r;
    ram_wdata   = {1'b1, len_r};
    ram_raddr   = j_r;

    case (state_r)
      S_IDLE: begin
        if (acc) begin
          seq_nxt  = in_seq_num;
          len_nxt  = in_payload_len;
          ok_nxt   = in_check_ok;
          zero_nxt = (seq_dist == '0);
          if (fin_r) begin
            // session finished: word ignored
          end else if (in_flag_kind == FLAG_FIN && in_payload_len == '0 && in_check_ok) begin
            fin_nxt     = 1'b1;
            ov_nxt      = 1'b1;
            ok_kind_nxt = KIND_FIN;
            oseq_nxt    = in_seq_num;
            oslot_nxt   = '0;
            olen_nxt    = '0;
            olast_nxt   = 1'b1;
          end else if (in_flag_kind != FLAG_NONE) begin
            // flagged: dropped
          end else if (is_old) begin
            ov_nxt      = 1'b1;
            ok_kind_nxt = KIND_ACK;
            oseq_nxt    = in_seq_num;
            oslot_nxt   = '0;
            olen_nxt    = '0;
            olast_nxt   = 1'b1;
          end else if (!beyond) begin
            mod_go    = 1'b1;
            state_nxt = S_MOD;
          end
        end
      end
      S_MOD: begin
        if (mod_done) begin
          idx_nxt   = mod_rem[SLOT_W-1:0];
          ram_raddr = mod_rem[SLOT_W-1:0];
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        state_nxt = S_IDLE;
        if (vld_r[idx_r] && ram_rdata[LEN_BITS]) begin
          // duplicate: re-ack
          ov_nxt      = 1'b1;
          ok_kind_nxt = KIND_ACK;
          oseq_nxt    = seq_r;
          oslot_nxt   = '0;
          olen_nxt    = '0;
          olast_nxt   = 1'b1;
        end else if (ok_r) begin
          ov_nxt      = 1'b1;
          ok_kind_nxt = KIND_ACK;
          oseq_nxt    = seq_r;
          oslot_nxt   = idx_r;
          olen_nxt    = len_r;
          if (!zero_r) begin
            ram_we         = 1'b1;
            vld_nxt[idx_r] = 1'b1;
            olast_nxt      = 1'b1;
          end else begin
            // left edge: the ack goes out now and this slot is held as the pending delivery, the rest are looked up
            olast_nxt = 1'b0;
            pseq_nxt  = seq_r;
            pslot_nxt = idx_r;
            plen_nxt  = len_r;
            cnt_nxt   = WW'(1);
            j_nxt     = j_after_idx;
            ram_raddr = j_after_idx;
            state_nxt = S_FLUSH;
          end
        end
      end
      S_FLUSH: begin
        // pending delivery goes out once it is known whether another follows
        ov_nxt      = 1'b1;
        ok_kind_nxt = KIND_DELIVER;
        oseq_nxt    = pseq_r;
        oslot_nxt   = pslot_r;
        olen_nxt    = plen_r;
        if (cand) begin
          olast_nxt = 1'b0;
          pseq_nxt  = left_r + SEQ_W'(cnt_r);
          pslot_nxt = j_r;
          plen_nxt  = ram_rdata[LEN_BITS-1:0];
          ram_we    = 1'b1;
          ram_waddr = j_r;
          ram_wdata = {1'b0, ram_rdata[LEN_BITS-1:0]};
          cnt_nxt   = cnt_r + WW'(1);
          j_nxt     = j_after_j;
          ram_raddr = j_after_j;
        end else begin
          olast_nxt = 1'b1;
          left_nxt  = left_r + SEQ_W'(cnt_r);
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cfg_we) begin
      case (cfg_index)
        REG_WINDOW_LEN: begin
          wlen_nxt = cfg_data[WLEN_W-1:0];
        end
        REG_START_SEQ: begin
          left_nxt = cfg_data[SEQ_W-1:0];
          vld_nxt  = '0;
          fin_nxt  = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      wlen_r  <= (WLEN_RST > WMAX_L) ? WMAX_L : WLEN_RST;
      left_r  <= '0;
      fin_r   <= 1'b0;
      vld_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      wlen_r  <= wlen_nxt;
      left_r  <= left_nxt;
      fin_r   <= fin_nxt;
      vld_r   <= vld_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    seq_r     <= seq_nxt;
    len_r     <= len_nxt;
    ok_r      <= ok_nxt;
    zero_r    <= zero_nxt;
    idx_r     <= idx_nxt;
    j_r       <= j_nxt;
    cnt_r     <= cnt_nxt;
    pseq_r    <= pseq_nxt;
    pslot_r   <= pslot_nxt;
    plen_r    <= plen_nxt;
    ok_kind_r <= ok_kind_nxt;
    oseq_r    <= oseq_nxt;
    oslot_r   <= oslot_nxt;
    olen_r    <= olen_nxt;
    olast_r   <= olast_nxt;
  end

  assign out_valid   = ov_r;
  assign out_kind    = ok_kind_r;
  assign out_seq_out = oseq_r;
  assign out_slot    = oslot_r;
  assign out_len_out = olen_r;
  assign out_last    = olast_r;

endmodule

### sim/tb_selective_repeat_receiver_window.sv
`timescale 1ns / 100ps
// testbench of the selective-repeat receiver window: directed and random headers, scoreboarded
module tb_selective_repeat_receiver_window;
  import srrw_pkg::*;

  localparam int WINDOW_MAX   = 32;
  localparam int LEN_BITS     = 11;
  localparam int SLOT_W       = 5;
  localparam int SETTLE_CYCLES = 60;
  localparam int LIMIT_CYCLES  = 600000;
  localparam int RANDOM_ITEMS  = 300;

  typedef struct packed {
    kind_t               kind;
    seq_t                seq;
    logic [SLOT_W-1:0]   slot;
    logic [LEN_BITS-1:0] len;
    logic                last;
  } header_result_t;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  seq_t                in_seq_num;
  flag_t               in_flag_kind;
  logic [LEN_BITS-1:0] in_payload_len;
  logic                in_check_ok;
  logic                out_valid;
  kind_t               out_kind;
  seq_t                out_seq_out;
  logic [SLOT_W-1:0]   out_slot;
  logic [LEN_BITS-1:0] out_len_out;
  logic                out_last;
  logic                cfg_we;
  cfg_idx_t            cfg_index;
  logic [CFG_W-1:0]    cfg_data;

  // mirror of the window state
  logic [WLEN_W-1:0]   mir_window_len;
  seq_t                mir_start_seq;
  logic                mir_acked [WINDOW_MAX];
  logic [LEN_BITS-1:0] mir_slot_len [WINDOW_MAX];
  seq_t                mir_left;
  seq_t                mir_finish_seq;
  logic                mir_finished;

  header_result_t      expected_results[$];
  header_result_t      seen_word;
  header_result_t      want_word;
  int                  mismatch_count;
  int                  cycle_count;
  int                  headers_taken;
  bit                  no_idle;

  selective_repeat_receiver_window #(
    .WINDOW_MAX(WINDOW_MAX),
    .LEN_BITS  (LEN_BITS)
  ) u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_seq_num    (in_seq_num),
    .in_flag_kind  (in_flag_kind),
    .in_payload_len(in_payload_len),
    .in_check_ok   (in_check_ok),
    .out_valid     (out_valid),
    .out_kind      (out_kind),
    .out_seq_out   (out_seq_out),
    .out_slot      (out_slot),
    .out_len_out   (out_len_out),
    .out_last      (out_last),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------- window mirror

  function automatic int eff_window();
    int w;
    w = mir_window_len;
    if (w < 1) w = 1;
    if (w > WINDOW_MAX) w = WINDOW_MAX;
    return w;
  endfunction

  function automatic void restart_session();
    for (int i = 0; i < WINDOW_MAX; i++) mir_acked[i] = 1'b0;
    mir_left       = mir_start_seq;
    mir_finish_seq = '0;
    mir_finished   = 1'b0;
  endfunction

  function automatic void apply_reg(cfg_idx_t idx, logic [CFG_W-1:0] data);
    if (idx == REG_WINDOW_LEN) begin
      mir_window_len = data[WLEN_W-1:0];
    end else begin
      mir_start_seq = data;
      restart_session();
    end
  endfunction

  function automatic header_result_t make_word(kind_t kind, seq_t seq, logic [31:0] slot,
                                               logic [LEN_BITS-1:0] len, logic last);
    header_result_t r;
    r.kind = kind;
    r.seq  = seq;
    r.slot = slot[SLOT_W-1:0];
    r.len  = len;
    r.last = last;
    return r;
  endfunction

  // returns 1 when the header was not ignored because of an earlier finish
  function automatic bit predict_header(seq_t seq, flag_t flag, logic [LEN_BITS-1:0] len,
                                        logic ok);
    logic [31:0]    w, d, idx, s, j;
    int             i;
    header_result_t pend;
    if (mir_finished) return 0;
    if (flag == FLAG_FIN && len == '0 && ok) begin
      mir_finish_seq = seq;
      mir_finished   = 1'b1;
      expected_results.push_back(make_word(KIND_FIN, seq, 0, '0, 1'b1));
      return 1;
    end
    if (flag != FLAG_NONE) return 1;
    w   = eff_window();
    d   = seq - mir_left;
    idx = seq % w;
    if (!d[31] && d >= w) return 1;
    if (d[31] || mir_acked[idx]) begin
      expected_results.push_back(make_word(KIND_ACK, seq, 0, '0, 1'b1));
      return 1;
    end
    if (!ok) return 1;
    mir_acked[idx]    = 1'b1;
    mir_slot_len[idx] = len;
    pend = make_word(KIND_ACK, seq, idx, len, 1'b0);
    if (d == 0) begin
      i = 0;
      s = mir_left;
      j = s % w;
      // in-order flush from the left edge
      while (i < w && mir_acked[j]) begin
        mir_acked[j] = 1'b0;
        expected_results.push_back(pend);
        pend = make_word(KIND_DELIVER, s, j, mir_slot_len[j], 1'b0);
        i++;
        s = mir_left + i;
        j = s % w;
      end
      mir_left = mir_left + i;
    end
    pend.last = 1'b1;
    expected_results.push_back(pend);
    return 1;
  endfunction

  // ---------------------------------------------------------------- result checking

  always @(posedge clk) begin
    if (rst_n && out_valid !== 1'b0) begin
      seen_word = make_word(out_kind, out_seq_out, 32'(out_slot), out_len_out, out_last);
      if (expected_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected word kind=%0d seq=%h slot=%0d len=%0d last=%b",
                 $time, seen_word.kind, seen_word.seq, seen_word.slot, seen_word.len,
                 seen_word.last);
      end else begin
        want_word = expected_results.pop_front();
        if (seen_word.kind !== want_word.kind || seen_word.seq !== want_word.seq ||
            seen_word.slot !== want_word.slot || seen_word.len !== want_word.len ||
            seen_word.last !== want_word.last) begin
          mismatch_count++;
          $display("%0t: mismatch expected kind=%0d seq=%h slot=%0d len=%0d last=%b",
                   $time, want_word.kind, want_word.seq, want_word.slot, want_word.len,
                   want_word.last);
          $display("%0t:          actual   kind=%0d seq=%h slot=%0d len=%0d last=%b",
                   $time, seen_word.kind, seen_word.seq, seen_word.slot, seen_word.len,
                   seen_word.last);
        end
      end
    end
  end

  // ---------------------------------------------------------------- driving

  function automatic int next_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [LEN_BITS-1:0] rand_len();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return LEN_BITS'($urandom_range(0, (1 << LEN_BITS) - 1));
    endcase
  endfunction

  task automatic send_header(seq_t seq, flag_t flag, logic [LEN_BITS-1:0] len, logic ok);
    int gap;
    gap = next_gap();
    if (gap > 0) begin
      @(negedge clk);
      start = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start          = 1'b1;
    in_seq_num     = seq;
    in_flag_kind   = flag;
    in_payload_len = len;
    in_check_ok    = ok;
    do @(posedge clk); while (busy);
    if (predict_header(seq, flag, len, ok)) headers_taken++;
  endtask

  // lower start and wait until the block has nothing left to say
  task automatic drain_results();
    @(negedge clk);
    start = 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(posedge clk);
    apply_reg(idx, data);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // ---------------------------------------------------------------- stimulus

  task automatic send_random_header();
    int          r, w;
    seq_t        seq;
    flag_t       flag;
    logic        ok;
    w    = eff_window();
    r    = $urandom_range(0, 99);
    flag = FLAG_NONE;
    ok   = ($urandom_range(0, 9) != 0);
    seq  = mir_left + $urandom_range(0, w - 1);
    if (r < 60) begin
      // in-window traffic, already set up
    end else if (r < 70) begin
      if ($urandom_range(0, 1)) seq = mir_left - $urandom_range(1, 64);
      else seq = mir_left + 32'h8000_0000 + $urandom_range(0, 32'h7FFF_FFFF);
    end else if (r < 78) begin
      if ($urandom_range(0, 1)) seq = mir_left + w + $urandom_range(0, 40);
      else seq = mir_left + $urandom_range(w, 32'h7FFF_FFFF);
    end else if (r < 86) begin
      seq  = $urandom;
      flag = flag_t'($urandom_range(0, 3));
      ok   = $urandom_range(0, 1);
      // keep clean finishes for phase ends
      if (flag == FLAG_FIN) ok = 1'b0;
    end else if (r < 93) begin
      flag = flag_t'($urandom_range(2, 3));
      ok   = $urandom_range(0, 1);
    end else begin
      flag = FLAG_FIN;
      if ($urandom_range(0, 1)) begin
        send_header(seq, flag, LEN_BITS'($urandom_range(1, (1 << LEN_BITS) - 1)),
                    $urandom_range(0, 1));
        return;
      end
      ok = 1'b0;
    end
    send_header(seq, flag, rand_len(), ok);
  endtask

  // every sequence of the window once, shuffled, usually with the left edge last
  task automatic send_shuffled_fill();
    int   order [WINDOW_MAX];
    int   w, i, j, tmp, hi;
    bit   left_last;
    seq_t base;
    w         = eff_window();
    base      = mir_left;
    left_last = ($urandom_range(0, 3) != 0);
    for (i = 0; i < w; i++) order[i] = left_last ? (i + 1) % w : i;
    hi = left_last ? w - 2 : w - 1;
    for (i = hi; i > 0; i--) begin
      j        = $urandom_range(0, i);
      tmp      = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    for (i = 0; i < w; i++)
      send_header(base + order[i], FLAG_NONE, rand_len(), $urandom_range(0, 15) != 0);
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_window_basics();
    // reset setting: window of 8 from sequence 0
    send_header(32'd0, FLAG_NONE, 11'd0, 1'b1);
    send_header(32'd2, FLAG_NONE, 11'h7FF, 1'b1);
    send_header(32'd1, FLAG_NONE, 11'h555, 1'b1);
    send_header(32'd1, FLAG_NONE, 11'h123, 1'b1);        // duplicate, re-ack
    send_header(32'd5, FLAG_NONE, 11'h0AA, 1'b0);        // new with bad checksum
    send_header(32'd4, FLAG_NONE, 11'h2AA, 1'b1);
    send_header(32'd4, FLAG_NONE, 11'h111, 1'b0);        // marked, bad checksum still acked
    send_header(32'd11, FLAG_NONE, 11'h001, 1'b1);       // one past the right edge
    send_header(32'h8000_0003, FLAG_NONE, 11'h3FF, 1'b1); // half-way round counts as old
    send_header(32'h8000_0002, FLAG_NONE, 11'h3FF, 1'b1); // furthest beyond the edge
    send_header(32'd3, flag_t'(2), 11'h010, 1'b1);
    send_header(32'd3, flag_t'(3), 11'h010, 1'b1);
    send_header(32'd3, FLAG_FIN, 11'd1, 1'b1);           // fin with payload
    send_header(32'd3, FLAG_FIN, 11'd0, 1'b0);           // fin with bad checksum
    send_header(32'd3, FLAG_NONE, 11'd7, 1'b1);
  endtask

  task automatic test_full_flush();
    // fill the window right to left, then close the left edge
    for (int k = 7; k >= 0; k--)
      send_header(mir_left + k, FLAG_NONE, rand_len(), 1'b1);
  endtask

  task automatic test_finish();
    send_header(32'hFFFF_FFFF, FLAG_FIN, 11'd0, 1'b1);
    send_header(mir_left, FLAG_NONE, 11'd9, 1'b1);       // ignored once finished
  endtask

  task automatic test_window_clamp();
    drain_results();
    write_reg(REG_WINDOW_LEN, 32'd0);
    write_reg(REG_START_SEQ, 32'hFFFF_FFFF);
    send_header(32'hFFFF_FFFF, FLAG_NONE, 11'h7FF, 1'b1);
    send_header(32'h0000_0000, FLAG_NONE, 11'h400, 1'b1);
    send_header(32'h0000_0000, FLAG_NONE, 11'h400, 1'b1);
    drain_results();
    write_reg(REG_WINDOW_LEN, 32'd63);
    write_reg(REG_START_SEQ, 32'h7FFF_FFFE);
    send_header(32'h7FFF_FFFF, FLAG_NONE, 11'h0F0, 1'b1);
    send_header(32'h7FFF_FFFE, FLAG_NONE, 11'h70F, 1'b1);
  endtask

  task automatic test_random_traffic();
    logic [WLEN_W-1:0] wlens [8];
    seq_t              starts [8];
    int                phase_target, phase_start;
    bit                paused;
    wlens  = '{6'd32, 6'd1, 6'd0, 6'd63, 6'd17, 6'd5, 6'd33, 6'd8};
    starts = '{32'hFFFF_FFF0, 32'h0, 32'hFFFF_FFFF, 32'h7FFF_FFF0,
               32'h0, 32'h8000_0000, 32'h0, 32'h0};
    starts[4]    = $urandom;
    starts[6]    = $urandom;
    phase_target = RANDOM_ITEMS / 8;
    for (int p = 0; p < 8; p++) begin
      drain_results();
      write_reg(REG_WINDOW_LEN, CFG_W'(wlens[p]));
      // phase 6 keeps the old session, unless it finished, so marked slots carry over the new length
      if (p != 6 || mir_finished) write_reg(REG_START_SEQ, starts[p]);
      no_idle     = (p == 2);
      paused      = 1'b0;
      phase_start = headers_taken;
      while (headers_taken - phase_start < phase_target) begin
        if (!paused && p == 3 && headers_taken - phase_start > phase_target / 2) begin
          drain_results();
          paused = 1'b1;
        end
        if ($urandom_range(0, 99) < 25) send_shuffled_fill();
        else send_random_header();
      end
      if ($urandom_range(0, 1)) begin
        send_header($urandom, FLAG_FIN, 11'd0, 1'b1);
        send_header(mir_left, FLAG_NONE, rand_len(), 1'b1);
        send_header($urandom, flag_t'($urandom_range(0, 3)), rand_len(), 1'b1);
      end
    end
    no_idle = 1'b0;
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    rst_n          = 1'b0;
    start          = 1'b0;
    in_seq_num     = '0;
    in_flag_kind   = FLAG_NONE;
    in_payload_len = '0;
    in_check_ok    = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = REG_WINDOW_LEN;
    cfg_data       = '0;
    mismatch_count = 0;
    cycle_count    = 0;
    headers_taken  = 0;
    no_idle        = 1'b0;
    mir_window_len = 6'd8;
    mir_start_seq  = '0;
    for (int i = 0; i < WINDOW_MAX; i++) mir_slot_len[i] = '0;
    restart_session();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_window_basics();
    test_full_flush();
    test_finish();
    test_window_clamp();
    test_random_traffic();
    drain_results();

    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
